// ===== hw/rtl/spd_pkg.sv =====
// Shared types, register codes and datapath widths for the stick pointer block.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
package spd_pkg;

    // Pointer coordinate width default and configuration port shape.
    localparam int COORD_BITS_DEF = 12;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H  = 2'd2;

    // Register reset values.
    localparam int DZ_W         = 15;
    localparam int DZ_RESET     = 7680;
    localparam int WIDTH_RESET  = 960;
    localparam int HEIGHT_RESET = 544;

    // Stick input: raw byte and its distance from the centre code.
    localparam int                STICK_W = 8;
    localparam logic [STICK_W-1:0] CENTRE = 8'd127;

    // Square root: 16-bit sum of squares, 24-bit root with 16 fraction bits.
    localparam int SQ_W        = 16;
    localparam int ROOT_W      = 24;
    localparam int ROOT_REM_W  = ROOT_W + 1;
    localparam int SQRT_STEPS  = ROOT_W;
    localparam int FRAC_BITS   = 8;

    // Rescale: numerator = |dx| * (m - d) << 23, denominator = m * (32768 - dz).
    localparam int SCALE_W     = 16;
    localparam int PROD_W      = STICK_W + ROOT_W;
    localparam int DEN_W       = ROOT_W + SCALE_W;
    localparam int QUO_W       = 30;
    localparam int FRAC_SHIFT  = 23;
    localparam int DIV_PRE     = QUO_W - FRAC_SHIFT;
    localparam int DIV_STEPS   = QUO_W;

    // Remainder accumulators and the pointer step.
    localparam int REM_W       = 12;
    localparam int SLOW_SHIFT  = 11;
    localparam int SUM_W       = 32;
    localparam int MOVE_W      = SUM_W - 1 - SLOW_SHIFT + 1;

    // Step counter of the sequencer.
    localparam int CNT_W       = $clog2(DIV_STEPS);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic sqrt_step;
        logic check;
        logic mul;
        logic div_step;
        logic acc;
        logic move;
        logic commit;
    } spd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic active;
    } spd_sts_t;

    // Distance of a raw stick byte from the centre code.
    function automatic logic [STICK_W-1:0] stick_dev(input logic [STICK_W-1:0] b);
        logic [STICK_W-1:0] d;
        if (b >= CENTRE) begin
            d = b - CENTRE;
        end else begin
            d = CENTRE - b;
        end
        return d;
    endfunction

endpackage

// ===== hw/rtl/spd_ctrl.sv =====
// Sequencer for the stick pointer block: input and result handshakes, step counts.
// Depends on spd_pkg for the command and status structs and the step counts.
module spd_ctrl
    import spd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  spd_sts_t sts,
    output spd_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SQRT  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_ACC   = 3'd5;
    localparam logic [2:0] ST_MOVE  = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    // Next state, step count and commands.
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = CNT_W'(SQRT_STEPS - 1);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_CHECK;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_CHECK: begin
                cmd.check  = 1'b1;
                state_next = sts.active ? ST_MUL : ST_ACC;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                cnt_next   = CNT_W'(DIV_STEPS - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_ACC;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_ACC: begin
                cmd.acc    = 1'b1;
                state_next = ST_MOVE;
            end
            ST_MOVE: begin
                cmd.move   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // Hold the new pointer until the result register is free.
                if (!m_valid_reg || m_ready) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== hw/rtl/spd_datapath.sv =====
// Datapath: configuration registers, square root, two divider lanes, accumulators.
// Depends on spd_pkg; driven step by step by spd_ctrl.
module spd_datapath
    import spd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [STICK_W-1:0]    s_stick_x,
    input  logic [STICK_W-1:0]    s_stick_y,
    input  logic                  s_left_trigger,
    input  logic                  s_right_trigger,
    output logic [COORD_BITS-1:0] m_pointer_x,
    output logic [COORD_BITS-1:0] m_pointer_y,
    output logic                  m_button_left,
    output logic                  m_button_right,
    input  spd_cmd_t              cmd,
    output spd_sts_t              sts
);

    localparam int PSUM_W = ((COORD_BITS > MOVE_W - 1) ? COORD_BITS : MOVE_W - 1) + 2;

    // Configuration registers.
    logic [DZ_W-1:0]       dz_reg;
    logic [COORD_BITS-1:0] lim_reg [2];

    // Latched sample, one lane per axis.
    logic [STICK_W-1:0] mag_reg [2];
    logic               neg_reg [2];
    logic               btn_l_reg, btn_r_reg;

    // Square root state.
    logic [SQ_W-1:0]       sq_sh_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [ROOT_REM_W-1:0] rrem_reg;

    // Rescale operands and divider lanes.
    logic [ROOT_W-1:0]  diff_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [DEN_W-1:0]   drem_reg [2];
    logic [QUO_W-1:0]   nbit_reg [2];
    logic [QUO_W-1:0]   quo_reg  [2];

    // Accumulators and pointer.
    logic signed [SUM_W-1:0]  sum_reg [2];
    logic signed [MOVE_W-1:0] mv_reg  [2];
    logic signed [REM_W-1:0]  rem_reg [2];
    logic [COORD_BITS-1:0]    pos_reg [2];
    logic                     btn_l_out_reg, btn_r_out_reg;

    // Sample decode and sum of squares at acceptance.
    logic [STICK_W-1:0] in_mag [2];
    logic [SQ_W-1:0]    in_sqr [2];
    logic [SQ_W:0]      in_sum;

    // Square root step.
    logic [ROOT_REM_W+1:0] sq_t;
    logic [ROOT_W+1:0]     sq_trial;
    logic [ROOT_REM_W+1:0] sq_diff;
    logic                  sq_ge;

    // Dead zone test.
    logic [ROOT_W-1:0] d8;
    logic              active;

    // Per-lane combinational values.
    logic [PROD_W-1:0]       prod    [2];
    logic [DEN_W-1:0]        den_c;
    logic [DEN_W:0]          dv_t    [2];
    logic [DEN_W:0]          dv_sub  [2];
    logic                    dv_ge   [2];
    logic signed [SUM_W-1:0] rx      [2];
    logic signed [SUM_W-1:0] rem_ext [2];
    logic [SUM_W-1:0]        sum_abs [2];
    logic [MOVE_W-1:0]       mv_abs  [2];
    logic [REM_W-1:0]        rm_abs  [2];
    logic signed [PSUM_W-1:0] pos_sum [2];
    logic [COORD_BITS-1:0]   pos_clamp [2];

    assign in_mag[0] = stick_dev(s_stick_x);
    assign in_mag[1] = stick_dev(s_stick_y);
    assign in_sqr[0] = in_mag[0] * in_mag[0];
    assign in_sqr[1] = in_mag[1] * in_mag[1];
    assign in_sum    = {1'b0, in_sqr[0]} + {1'b0, in_sqr[1]};

    // One root bit per step from the next bit pair of the shifted sum.
    assign sq_t     = {rrem_reg, sq_sh_reg[SQ_W-1 -: 2]};
    assign sq_trial = {root_reg, 2'b01};
    assign sq_ge    = sq_t >= {1'b0, sq_trial};
    assign sq_diff  = sq_t - {1'b0, sq_trial};

    // A stick on the zone boundary counts as outside.
    assign d8         = {1'b0, dz_reg, {FRAC_BITS{1'b0}}};
    assign active     = (root_reg != '0) && (root_reg >= d8);
    assign sts.active = active;

    assign den_c = DEN_W'(root_reg) * DEN_W'(scale_reg);

    // Lane arithmetic: product, divider step, accumulate, pointer step, clamp.
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            prod[i]   = PROD_W'(mag_reg[i]) * PROD_W'(diff_reg);
            dv_t[i]   = {drem_reg[i], nbit_reg[i][QUO_W-1]};
            dv_ge[i]  = dv_t[i] >= {1'b0, den_reg};
            dv_sub[i] = dv_t[i] - {1'b0, den_reg};

            rx[i] = '0;
            if (active) begin
                rx[i] = $signed({{(SUM_W-QUO_W){1'b0}}, quo_reg[i]});
                if (neg_reg[i]) begin
                    rx[i] = -rx[i];
                end
            end
            rem_ext[i] = $signed({{(SUM_W-REM_W){rem_reg[i][REM_W-1]}}, rem_reg[i]});

            sum_abs[i] = sum_reg[i][SUM_W-1] ? SUM_W'(-sum_reg[i]) : SUM_W'(sum_reg[i]);
            mv_abs[i]  = {1'b0, sum_abs[i][SUM_W-2:SLOW_SHIFT]};
            rm_abs[i]  = {1'b0, sum_abs[i][SLOW_SHIFT-1:0]};

            pos_sum[i] = $signed({{(PSUM_W-COORD_BITS){1'b0}}, pos_reg[i]})
                       + $signed({{(PSUM_W-MOVE_W){mv_reg[i][MOVE_W-1]}}, mv_reg[i]});
            if (pos_sum[i] < 0) begin
                pos_clamp[i] = '0;
            end else if (pos_sum[i] > $signed({{(PSUM_W-COORD_BITS){1'b0}}, lim_reg[i]})) begin
                pos_clamp[i] = lim_reg[i];
            end else begin
                pos_clamp[i] = pos_sum[i][COORD_BITS-1:0];
            end
        end
    end

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dz_reg     <= DZ_W'(DZ_RESET);
            lim_reg[0] <= COORD_BITS'(WIDTH_RESET);
            lim_reg[1] <= COORD_BITS'(HEIGHT_RESET);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_DEAD_ZONE: dz_reg     <= cfg_wdata[DZ_W-1:0];
                REG_SCREEN_W:  lim_reg[0] <= cfg_wdata[COORD_BITS-1:0];
                REG_SCREEN_H:  lim_reg[1] <= cfg_wdata[COORD_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Working registers; no reset needed.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mag_reg[0] <= in_mag[0];
            mag_reg[1] <= in_mag[1];
            neg_reg[0] <= s_stick_x < CENTRE;
            neg_reg[1] <= s_stick_y < CENTRE;
            btn_l_reg  <= s_left_trigger;
            btn_r_reg  <= s_right_trigger;
            sq_sh_reg  <= in_sum[SQ_W-1:0];
            root_reg   <= '0;
            rrem_reg   <= '0;
        end
        if (cmd.sqrt_step) begin
            sq_sh_reg <= {sq_sh_reg[SQ_W-3:0], 2'b00};
            root_reg  <= {root_reg[ROOT_W-2:0], sq_ge};
            rrem_reg  <= sq_ge ? sq_diff[ROOT_REM_W-1:0] : sq_t[ROOT_REM_W-1:0];
        end
        if (cmd.check) begin
            diff_reg  <= root_reg - d8;
            scale_reg <= {1'b1, {(SCALE_W-1){1'b0}}} - {1'b0, dz_reg};
        end
        if (cmd.mul) begin
            den_reg <= den_c;
        end
        for (int i = 0; i < 2; i++) begin
            if (cmd.mul) begin
                drem_reg[i] <= DEN_W'(prod[i][PROD_W-1:DIV_PRE]);
                nbit_reg[i] <= {prod[i][DIV_PRE-1:0], {FRAC_SHIFT{1'b0}}};
                quo_reg[i]  <= '0;
            end
            if (cmd.div_step) begin
                drem_reg[i] <= dv_ge[i] ? dv_sub[i][DEN_W-1:0] : dv_t[i][DEN_W-1:0];
                nbit_reg[i] <= {nbit_reg[i][QUO_W-2:0], 1'b0};
                quo_reg[i]  <= {quo_reg[i][QUO_W-2:0], dv_ge[i]};
            end
            if (cmd.acc) begin
                sum_reg[i] <= rem_ext[i] + rx[i];
            end
            if (cmd.move) begin
                mv_reg[i] <= sum_reg[i][SUM_W-1] ? -$signed(mv_abs[i]) : $signed(mv_abs[i]);
            end
        end
    end

    // Remainders, pointer and result payload.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 2; i++) begin
                rem_reg[i] <= '0;
                pos_reg[i] <= '0;
            end
            btn_l_out_reg <= 1'b0;
            btn_r_out_reg <= 1'b0;
        end else begin
            for (int i = 0; i < 2; i++) begin
                if (cmd.move) begin
                    rem_reg[i] <= sum_reg[i][SUM_W-1] ? -$signed(rm_abs[i]) : $signed(rm_abs[i]);
                end
                if (cmd.commit) begin
                    pos_reg[i] <= pos_clamp[i];
                end
            end
            if (cmd.commit) begin
                btn_l_out_reg <= btn_l_reg;
                btn_r_out_reg <= btn_r_reg;
            end
        end
    end

    assign m_pointer_x    = pos_reg[0];
    assign m_pointer_y    = pos_reg[1];
    assign m_button_left  = btn_l_out_reg;
    assign m_button_right = btn_r_out_reg;

endmodule

// ===== hw/rtl/stick_pointer_deadzone.sv =====
// Each request runs the 24-step square root, the dead zone check, then outside the dead zone
// the multiply and the 30-step restoring divider (both axes in parallel), then accumulate,
// move and commit. A new request is taken only after the last one has been committed.
// A finished result waits in the output register without blocking the next request.
// Reset (aresetn, synchronous, active low) zeroes pointer and remainders and restores
// dead_zone 7680, screen_width 960, screen_height 544. The config port is always ready.
module stick_pointer_deadzone
    import spd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [STICK_W-1:0]    s_stick_x,
    input  logic [STICK_W-1:0]    s_stick_y,
    input  logic                  s_left_trigger,
    input  logic                  s_right_trigger,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COORD_BITS-1:0] m_pointer_x,
    output logic [COORD_BITS-1:0] m_pointer_y,
    output logic                  m_button_left,
    output logic                  m_button_right
);

    spd_cmd_t cmd;
    spd_sts_t sts;

    assign cfg_ready = 1'b1;

    // Sequencer.
    spd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Arithmetic and state.
    spd_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_stick_x       (s_stick_x),
        .s_stick_y       (s_stick_y),
        .s_left_trigger  (s_left_trigger),
        .s_right_trigger (s_right_trigger),
        .m_pointer_x     (m_pointer_x),
        .m_pointer_y     (m_pointer_y),
        .m_button_left   (m_button_left),
        .m_button_right  (m_button_right),
        .cmd             (cmd),
        .sts             (sts)
    );

endmodule

// ===== hw/rtl/spd_checker.sv =====
// Port-level checks for stick_pointer_deadzone, attached by the bind at the end.
// Depends on spd_pkg for the default coordinate width.
module spd_checker
    import spd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [COORD_BITS-1:0] m_pointer_x,
    input logic [COORD_BITS-1:0] m_pointer_y,
    input logic                  m_button_left,
    input logic                  m_button_right
);

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pointer_x) && $stable(m_pointer_y)
            && $stable(m_button_left) && $stable(m_button_right))
        else $error("result changed while stalled");

    // After a request is taken the block is busy at the start of the square root.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready ##1 !s_ready)
        else $error("request taken while busy");

    // A new result only appears at the end of work on a request.
    a_new_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared without work");

    // Once a result is posted the block is ready for the next request.
    a_free_after: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("not ready after posting a result");

endmodule

bind stick_pointer_deadzone spd_checker #(
    .COORD_BITS (COORD_BITS)
) u_spd_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_pointer_x    (m_pointer_x),
    .m_pointer_y    (m_pointer_y),
    .m_button_left  (m_button_left),
    .m_button_right (m_button_right)
);
